// ===== sv/stla_pkg.sv =====
`default_nettype none

package stla_pkg;

  // default table size and id range
  localparam int unsigned SlotsDef = 32;
  localparam int unsigned IdMaxDef = 32767;

  // fixed field widths
  localparam int unsigned IdW     = 15;
  localparam int unsigned StampW  = 32;
  localparam int unsigned LvlW    = 8;
  localparam int unsigned IdxOutW = 5;

  // request codes
  typedef enum logic [1:0] {
    FuncAlloc  = 2'd0,
    FuncLookup = 2'd1,
    FuncFree   = 2'd2,
    FuncClear  = 2'd3
  } stla_func_e;

  // input beat
  typedef struct packed {
    stla_func_e       func;
    logic [IdW-1:0]   floor_key;
    logic [IdW-1:0]   current_floor;
    logic [LvlW-1:0]  level;
  } stla_in_t;

  // output beat
  typedef struct packed {
    logic [IdW-1:0]     result_id;
    logic [IdxOutW-1:0] slot_index;
    logic               hit;
    logic [LvlW-1:0]    slot_level;
    logic               evicted;
    logic               file_delete;
    logic               current_cleared;
  } stla_out_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [StampW-1:0] stamp;
    logic [LvlW-1:0]   lvl;
  } stla_entry_t;

endpackage

`default_nettype wire

// ===== sv/slot_table_allocator_lru.sv =====
// Slot table allocator with least-recently-stamped eviction.
// Input channel in_valid_i / in_stall_o carries one request beat (in_data_i):
// allocate, lookup by id, free by id, or clear all. Output channel
// out_valid_o / out_stall_i returns exactly one result beat per request.
// Every request other than clear walks the whole table through the single
// read port of the slot memory, one entry per cycle, then goes to state S_FIN,
// where an allocate writes its entry and a free clears its slot. The result
// passes from S_FIN through S_DONE to the output register, and a new request
// is taken once the state is back at S_IDLE. Clear all skips the scan.
// One request is in flight at a time; in_stall_o is high while it is.
// The result sits in an output register, so a request may be accepted while
// the previous result still waits; if the receiver keeps out_stall_i high,
// the finished result is held and the next one waits behind it.
// Reset empties the table at once (occupied bits are flip-flops), sets the
// next id and the stamp counter to 1 and drops any pending result.
`default_nettype none

module slot_table_allocator_lru #(
  parameter int unsigned SLOTS  = stla_pkg::SlotsDef,
  parameter int unsigned ID_MAX = stla_pkg::IdMaxDef,
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CntW  = $clog2(SLOTS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire stla_pkg::stla_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output stla_pkg::stla_out_t      out_data_o
);
  import stla_pkg::*;

  localparam logic [IdW-1:0]    IdMaxC  = IdW'(ID_MAX);
  localparam logic [IdW-1:0]    IdOne   = IdW'(1);
  localparam logic [StampW-1:0] StampOne = StampW'(1);
  localparam logic [CntW-1:0]   SlotsC  = CntW'(SLOTS);
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  stla_in_t          req_q, req_d;
  stla_out_t         res_q, res_d;
  stla_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [IdW-1:0]    next_id_q, next_id_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [CntW-1:0]   addr_q, addr_d;
  logic              beat_q, beat_d;
  logic [IdxW-1:0]   beat_idx_q, beat_idx_d;

  // scan results
  logic              free_fnd_q, free_fnd_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic              mat_fnd_q, mat_fnd_d;
  logic [IdxW-1:0]   mat_idx_q, mat_idx_d;
  logic [LvlW-1:0]   mat_lvl_q, mat_lvl_d;
  logic              old_fnd_q, old_fnd_d;
  logic [IdxW-1:0]   old_idx_q, old_idx_d;
  logic [StampW-1:0] old_stamp_q, old_stamp_d;

  // memory side
  logic              rd_en;
  logic              rd_valid;
  stla_entry_t       rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  stla_entry_t       wr_data;
  logic              clr_en;
  logic              clr_all;
  logic [IdW-1:0]    beat_id;
  logic              accept;
  logic [IdxW-1:0]   sel_idx;
  logic [IdxW+IdxOutW-1:0] sel_ext;

  stla_slot_ram #(
    .Slots(SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q[IdxW-1:0]),
    .rd_valid_o(rd_valid),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_en_i  (clr_en),
    .clr_addr_i(mat_idx_q),
    .clr_all_i (clr_all)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign rd_en       = (state_q == S_SCAN) && (addr_q < SlotsC);
  assign beat_id     = rd_valid ? rd_data.id : '0;

  // slot chosen by an allocate
  always_comb begin
    if (free_fnd_q) begin
      sel_idx = free_idx_q;
    end else if (old_fnd_q) begin
      sel_idx = old_idx_q;
    end else begin
      sel_idx = '0;
    end
  end

  // main control: scan, write-back, result
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    next_id_d   = next_id_q;
    stamp_d     = stamp_q;
    addr_d      = addr_q;
    beat_d      = rd_en;
    beat_idx_d  = addr_q[IdxW-1:0];
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;
    mat_fnd_d   = mat_fnd_q;
    mat_idx_d   = mat_idx_q;
    mat_lvl_d   = mat_lvl_q;
    old_fnd_d   = old_fnd_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    wr_en       = 1'b0;
    wr_addr     = sel_idx;
    wr_data     = '{id: next_id_q, stamp: stamp_q, lvl: req_q.level};
    clr_en      = 1'b0;
    clr_all     = 1'b0;
    sel_ext     = {{IdxOutW{1'b0}}, sel_idx};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d       = in_data_i;
          addr_d      = '0;
          free_fnd_d  = 1'b0;
          mat_fnd_d   = 1'b0;
          old_fnd_d   = 1'b0;
          old_idx_d   = '0;
          old_stamp_d = '1;
          if (in_data_i.func == FuncClear) begin
            clr_all   = 1'b1;
            next_id_d = IdOne;
            stamp_d   = StampOne;
            res_d     = '0;
            state_d   = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rd_en) begin
          addr_d = addr_q + CntW'(1);
        end
        // one entry per beat, lowest index wins for free and match
        if (beat_q) begin
          if (!rd_valid && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = beat_idx_q;
          end
          if (rd_valid && (req_q.floor_key != '0) && (rd_data.id == req_q.floor_key)
              && !mat_fnd_q) begin
            mat_fnd_d = 1'b1;
            mat_idx_d = beat_idx_q;
            mat_lvl_d = rd_data.lvl;
          end
          // oldest unprotected entry, a tie goes to the later slot
          if ((beat_id != req_q.current_floor) && (rd_data.stamp <= old_stamp_q)) begin
            old_fnd_d   = 1'b1;
            old_idx_d   = beat_idx_q;
            old_stamp_d = rd_data.stamp;
          end
          if (beat_idx_q == LastIdx) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        res_d   = '0;
        state_d = S_DONE;
        case (req_q.func)
          FuncAlloc: begin
            wr_en                 = 1'b1;
            res_d.result_id       = next_id_q;
            res_d.slot_index      = sel_ext[IdxOutW-1:0];
            res_d.evicted         = !free_fnd_q;
            res_d.file_delete     = !free_fnd_q && old_fnd_q;
            res_d.current_cleared = !free_fnd_q && !old_fnd_q;
            stamp_d               = stamp_q + StampOne;
            next_id_d             = (next_id_q < IdMaxC) ? next_id_q + IdOne : IdOne;
          end
          FuncLookup: begin
            if (mat_fnd_q) begin
              sel_ext          = {{IdxOutW{1'b0}}, mat_idx_q};
              res_d.result_id  = req_q.floor_key;
              res_d.slot_index = sel_ext[IdxOutW-1:0];
              res_d.hit        = 1'b1;
              res_d.slot_level = mat_lvl_q;
            end
          end
          FuncFree: begin
            if (mat_fnd_q) begin
              clr_en                = 1'b1;
              sel_ext               = {{IdxOutW{1'b0}}, mat_idx_q};
              res_d.slot_index      = sel_ext[IdxOutW-1:0];
              res_d.hit             = 1'b1;
              res_d.current_cleared = (req_q.floor_key == req_q.current_floor);
              res_d.file_delete     = (req_q.floor_key != req_q.current_floor);
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      next_id_q   <= IdOne;
      stamp_q     <= StampOne;
      addr_q      <= '0;
      beat_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      next_id_q   <= next_id_d;
      stamp_q     <= stamp_d;
      addr_q      <= addr_d;
      beat_q      <= beat_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    beat_idx_q  <= beat_idx_d;
    free_fnd_q  <= free_fnd_d;
    free_idx_q  <= free_idx_d;
    mat_fnd_q   <= mat_fnd_d;
    mat_idx_q   <= mat_idx_d;
    mat_lvl_q   <= mat_lvl_d;
    old_fnd_q   <= old_fnd_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
  end

endmodule

`default_nettype wire

// ===== sv/stla_slot_ram.sv =====
`default_nettype none

module stla_slot_ram #(
  parameter int unsigned Slots = stla_pkg::SlotsDef,
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // read port, registered data
  input  wire logic                  rd_en_i,
  input  wire logic [IdxW-1:0]       rd_addr_i,
  output logic                       rd_valid_o,
  output stla_pkg::stla_entry_t      rd_data_o,
  // write port, marks the entry occupied
  input  wire logic                  wr_en_i,
  input  wire logic [IdxW-1:0]       wr_addr_i,
  input  wire stla_pkg::stla_entry_t wr_data_i,
  // free one entry or all of them
  input  wire logic                  clr_en_i,
  input  wire logic [IdxW-1:0]       clr_addr_i,
  input  wire logic                  clr_all_i
);
  import stla_pkg::*;

  stla_entry_t mem_q [Slots];
  logic [Slots-1:0] occ_q;
  logic             rd_valid_q;

  // entry storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

  // occupied bits, a free entry reads as id zero upstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_all_i) begin
        occ_q <= '0;
      end else begin
        if (wr_en_i) begin
          occ_q[wr_addr_i] <= 1'b1;
        end
        if (clr_en_i) begin
          occ_q[clr_addr_i] <= 1'b0;
        end
      end
      if (rd_en_i) begin
        rd_valid_q <= occ_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire
